>>> sv/sensor_measure_sequencer_top_assert.svh
// Assertion macros for the sensor measure sequencer.
`ifndef SENSOR_MEASURE_SEQUENCER_TOP_ASSERT_SVH
`define SENSOR_MEASURE_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sms_pkg.sv
// Types, constants and helpers shared by the sensor measure sequencer.
`default_nettype none
package sms_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int LEVEL_BITS  = 12;
    localparam int CMP_BITS    = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;
    localparam int RETRY_BITS  = 4;
    localparam int BLINK_BITS  = 4;
    localparam int ADDR_BITS   = 5;
    localparam int DATA_BITS   = 32;

    // event kinds
    localparam logic [1:0] FUNC_TICK      = 2'd0;
    localparam logic [1:0] FUNC_START     = 2'd1;
    localparam logic [1:0] FUNC_SEND_OK   = 2'd2;
    localparam logic [1:0] FUNC_SEND_FAIL = 2'd3;

    // measurement outcome codes
    localparam logic [1:0] OUTCOME_NONE = 2'd0;
    localparam logic [1:0] OUTCOME_OK   = 2'd1;
    localparam logic [1:0] OUTCOME_FAIL = 2'd2;

    // blink pattern kinds
    localparam logic [1:0] KIND_MEAS_OK   = 2'd0;
    localparam logic [1:0] KIND_MEAS_FAIL = 2'd1;
    localparam logic [1:0] KIND_SEND_OK   = 2'd2;
    localparam logic [1:0] KIND_SEND_FAIL = 2'd3;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_CHARGE_OFF = 3'd0;
    localparam logic [2:0] REG_CHARGE_ON  = 3'd1;
    localparam logic [2:0] REG_DAYLIGHT   = 3'd2;
    localparam logic [2:0] REG_DARKNESS   = 3'd3;
    localparam logic [2:0] REG_RETRY      = 3'd4;

    localparam logic [LEVEL_BITS-1:0] CHARGE_OFF_RESET = LEVEL_BITS'(3723);
    localparam logic [LEVEL_BITS-1:0] CHARGE_ON_RESET  = LEVEL_BITS'(3549);
    localparam logic [LEVEL_BITS-1:0] DAYLIGHT_RESET   = LEVEL_BITS'(20);
    localparam logic [LEVEL_BITS-1:0] DARKNESS_RESET   = LEVEL_BITS'(10);
    localparam logic [RETRY_BITS-1:0] RETRY_RESET      = RETRY_BITS'(10);

    typedef struct packed {
        logic [1:0]             func;
        logic                   temp_ready;
        logic                   humid_ready;
        logic [SAMPLE_BITS-1:0] battery_sample;
        logic [SAMPLE_BITS-1:0] solar_sample;
    } evt_beat_t;

    typedef struct packed {
        logic       charger_switch;
        logic       lamp_drive;
        logic       indicator_led;
        logic       reference_power;
        logic       start_temp_pulse;
        logic       start_humid_pulse;
        logic       sample_taken;
        logic [1:0] measure_outcome;
        logic       measuring;
    } res_beat_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] charge_off_level;
        logic [LEVEL_BITS-1:0] charge_on_level;
        logic [LEVEL_BITS-1:0] daylight_level;
        logic [LEVEL_BITS-1:0] darkness_level;
        logic [RETRY_BITS-1:0] retry_limit;
    } cfg_t;

    function automatic logic [BLINK_BITS-1:0] blink_len(input logic [1:0] kind);
        logic [BLINK_BITS-1:0] len;
        unique case (kind)
            KIND_MEAS_OK:   len = BLINK_BITS'(3);
            KIND_MEAS_FAIL: len = BLINK_BITS'(6);
            KIND_SEND_OK:   len = BLINK_BITS'(8);
            KIND_SEND_FAIL: len = BLINK_BITS'(14);
            default:        len = BLINK_BITS'(3);
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

>>> sv/sensor_measure_sequencer_top.sv
// Top level of the sensor measure sequencer: handshake stages around the step core.
//
//  channel  dir  handshake          beat
//  evt      in   evt_valid/stall    sms_pkg::evt_beat_t
//  res      out  res_valid/stall    sms_pkg::res_beat_t
//  apb      in   psel/penable       5 config registers at byte address 4*i
//
// One event per cycle sustained while the result is not stalled; a taken event
// loads the input register, its step result then loads the result register and
// raises res_valid, unless a result stall holds the event in the input register.
// Reset clears all sequencer state and loads the register defaults.
// A stalled result holds; the input register still takes an event when the
// result register drains in the same cycle.
`default_nettype none
module sensor_measure_sequencer_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          evt_valid,
    output logic                               evt_stall,
    input  wire sms_pkg::evt_beat_t            evt,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output sms_pkg::res_beat_t                 res,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sms_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [sms_pkg::DATA_BITS-1:0] pwdata,
    output logic      [sms_pkg::DATA_BITS-1:0] prdata,
    output logic                               pready
);

    logic               stage_valid_reg;
    logic               stage_valid_next;
    sms_pkg::evt_beat_t stage_reg;
    logic               res_valid_reg;
    logic               res_valid_next;
    sms_pkg::res_beat_t res_reg;
    sms_pkg::res_beat_t step_res;
    sms_pkg::cfg_t      cfg;
    logic               advance;
    logic               take;

    assign pready = 1'b1;

    sms_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    sms_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .evt     (stage_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    assign advance   = stage_valid_reg && (!res_valid_reg || !res_stall);
    assign evt_stall = stage_valid_reg && !advance;
    assign take      = evt_valid && !evt_stall;

    always_comb
    begin
        priority if (take)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;

        priority if (advance)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            stage_reg <= evt;
        if (advance)
            res_reg <= step_res;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`include "sensor_measure_sequencer_top_assert.svh"

    `SMS_ASSERT_NOW(a_sample_drops_ref, res_valid && res.sample_taken,
        !res.reference_power, "reference still powered on a sampling beat")
    `SMS_ASSERT_NOW(a_start_sets_wait, res_valid && res.start_temp_pulse,
        res.measuring && res.reference_power, "start beat without active wait")
    `SMS_ASSERT_NEXT(a_stage_held, stage_valid_reg && res_valid_reg && res_stall,
        stage_valid_reg, "pending event lost while result stalled")

endmodule
`default_nettype wire

>>> sv/sms_cfg.sv
// Configuration register file with its APB-style access port.
`default_nettype none
module sms_cfg
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sms_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [sms_pkg::DATA_BITS-1:0] pwdata,
    output logic      [sms_pkg::DATA_BITS-1:0] prdata,
    output sms_pkg::cfg_t                      cfg
);

    sms_pkg::cfg_t cfg_reg;
    sms_pkg::cfg_t cfg_next;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                sms_pkg::REG_CHARGE_OFF:
                    cfg_next.charge_off_level = pwdata[sms_pkg::LEVEL_BITS-1:0];
                sms_pkg::REG_CHARGE_ON:
                    cfg_next.charge_on_level = pwdata[sms_pkg::LEVEL_BITS-1:0];
                sms_pkg::REG_DAYLIGHT:
                    cfg_next.daylight_level = pwdata[sms_pkg::LEVEL_BITS-1:0];
                sms_pkg::REG_DARKNESS:
                    cfg_next.darkness_level = pwdata[sms_pkg::LEVEL_BITS-1:0];
                sms_pkg::REG_RETRY:
                    cfg_next.retry_limit = pwdata[sms_pkg::RETRY_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.charge_off_level <= sms_pkg::CHARGE_OFF_RESET;
            cfg_reg.charge_on_level  <= sms_pkg::CHARGE_ON_RESET;
            cfg_reg.daylight_level   <= sms_pkg::DAYLIGHT_RESET;
            cfg_reg.darkness_level   <= sms_pkg::DARKNESS_RESET;
            cfg_reg.retry_limit      <= sms_pkg::RETRY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            sms_pkg::REG_CHARGE_OFF:
                prdata = sms_pkg::DATA_BITS'(cfg_reg.charge_off_level);
            sms_pkg::REG_CHARGE_ON:
                prdata = sms_pkg::DATA_BITS'(cfg_reg.charge_on_level);
            sms_pkg::REG_DAYLIGHT:
                prdata = sms_pkg::DATA_BITS'(cfg_reg.daylight_level);
            sms_pkg::REG_DARKNESS:
                prdata = sms_pkg::DATA_BITS'(cfg_reg.darkness_level);
            sms_pkg::REG_RETRY:
                prdata = sms_pkg::DATA_BITS'(cfg_reg.retry_limit);
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

>>> sv/sms_core.sv
// Sequencer state and the single-pass event step logic.
`default_nettype none
module sms_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step_en,
    input  wire sms_pkg::evt_beat_t evt,
    input  wire sms_pkg::cfg_t      cfg,
    output sms_pkg::res_beat_t      res
);

    typedef struct packed {
        logic                           active;
        logic                           led;
        logic [1:0]                     kind;
        logic [sms_pkg::BLINK_BITS-1:0] left;
    } blink_t;

    typedef struct packed {
        logic                           check_pending;
        logic                           temp_wait;
        logic                           humid_wait;
        logic [sms_pkg::RETRY_BITS-1:0] retries_left;
        blink_t                         blink;
        logic                           charger_on;
        logic                           lamp_on;
        logic                           reference_level;
    } state_t;

    state_t st_reg;
    state_t st_next;
    logic   pulse_t;
    logic   pulse_h;
    logic   sampled;
    logic [1:0] outcome;
    logic [sms_pkg::CMP_BITS-1:0] bat;
    logic [sms_pkg::CMP_BITS-1:0] sol;

    // a new pattern is dropped while one is running
    function automatic blink_t start_blink(input blink_t b, input logic [1:0] kind);
        blink_t r;
        r = b;
        if (!b.active)
        begin
            r.active = 1'b1;
            r.led    = 1'b1;
            r.kind   = kind;
            r.left   = sms_pkg::blink_len(kind);
        end
        return r;
    endfunction

    assign bat = sms_pkg::CMP_BITS'(evt.battery_sample);
    assign sol = sms_pkg::CMP_BITS'(evt.solar_sample);

    always_comb
    begin
        st_next = st_reg;
        pulse_t = 1'b0;
        pulse_h = 1'b0;
        sampled = 1'b0;
        outcome = sms_pkg::OUTCOME_NONE;
        unique case (evt.func)
            sms_pkg::FUNC_TICK:
            begin
                if (st_next.blink.active)
                begin
                    st_next.blink.left = st_next.blink.left - 1'b1;
                    if (st_next.blink.left == '0)
                    begin
                        st_next.blink.active = 1'b0;
                        st_next.blink.led    = 1'b0;
                    end
                    else if ((st_next.blink.kind == sms_pkg::KIND_MEAS_FAIL ||
                              st_next.blink.kind == sms_pkg::KIND_SEND_FAIL) &&
                             !st_next.blink.left[0])
                    begin
                        st_next.blink.led = !st_next.blink.led;
                    end
                end
                if (st_next.check_pending)
                begin
                    st_next.reference_level = 1'b0;
                    sampled = 1'b1;
                    st_next.check_pending = 1'b0;
                    // open test first: it wins when thresholds cross
                    if (bat >= sms_pkg::CMP_BITS'(cfg.charge_off_level))
                        st_next.charger_on = 1'b0;
                    else if (bat <= sms_pkg::CMP_BITS'(cfg.charge_on_level))
                        st_next.charger_on = 1'b1;
                    if (sol >= sms_pkg::CMP_BITS'(cfg.daylight_level))
                        st_next.lamp_on = 1'b0;
                    else if (sol <= sms_pkg::CMP_BITS'(cfg.darkness_level))
                        st_next.lamp_on = 1'b1;
                end
                if (st_next.temp_wait)
                begin
                    if (st_next.retries_left == '0)
                    begin
                        st_next.temp_wait = 1'b0;
                        outcome = sms_pkg::OUTCOME_FAIL;
                        st_next.blink = start_blink(st_next.blink, sms_pkg::KIND_MEAS_FAIL);
                    end
                    else
                    begin
                        st_next.retries_left = st_next.retries_left - 1'b1;
                        if (evt.temp_ready)
                        begin
                            pulse_h = 1'b1;
                            st_next.temp_wait    = 1'b0;
                            st_next.humid_wait   = 1'b1;
                            st_next.retries_left = cfg.retry_limit;
                        end
                    end
                end
                // humidity wait sees the counter as the temperature step left it
                if (st_next.humid_wait)
                begin
                    if (st_next.retries_left == '0)
                    begin
                        st_next.humid_wait = 1'b0;
                        outcome = sms_pkg::OUTCOME_FAIL;
                        st_next.blink = start_blink(st_next.blink, sms_pkg::KIND_MEAS_FAIL);
                    end
                    else
                    begin
                        st_next.retries_left = st_next.retries_left - 1'b1;
                        if (evt.humid_ready)
                        begin
                            st_next.humid_wait = 1'b0;
                            outcome = sms_pkg::OUTCOME_OK;
                            st_next.blink = start_blink(st_next.blink, sms_pkg::KIND_MEAS_OK);
                        end
                    end
                end
            end
            sms_pkg::FUNC_START:
            begin
                pulse_t = 1'b1;
                st_next.temp_wait       = 1'b1;
                st_next.retries_left    = cfg.retry_limit;
                st_next.reference_level = 1'b1;
                st_next.check_pending   = 1'b1;
            end
            sms_pkg::FUNC_SEND_OK:
                st_next.blink = start_blink(st_next.blink, sms_pkg::KIND_SEND_OK);
            sms_pkg::FUNC_SEND_FAIL:
                st_next.blink = start_blink(st_next.blink, sms_pkg::KIND_SEND_FAIL);
            default:
                st_next = st_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (step_en)
            st_reg <= st_next;
    end

    always_comb
    begin
        res.charger_switch    = st_next.charger_on;
        res.lamp_drive        = st_next.lamp_on;
        res.indicator_led     = st_next.blink.led;
        res.reference_power   = st_next.reference_level;
        res.start_temp_pulse  = pulse_t;
        res.start_humid_pulse = pulse_h;
        res.sample_taken      = sampled;
        res.measure_outcome   = outcome;
        res.measuring         = st_next.temp_wait || st_next.humid_wait;
    end

endmodule
`default_nettype wire
